>>> rtl/core/vda_pkg.sv
package vda_pkg;

   localparam int ORIGIN_W = 21;
   localparam int WIDTH_W  = 16;
   localparam int POS_W    = 21;
   localparam int ENERGY_W = 32;
   localparam int DENS_W   = 15;
   localparam int WGT_W    = 32;
   localparam int RIDX_W   = 6;
   localparam int SUM_W    = 64;
   localparam int OFF_W    = 22;
   localparam int DENOM_W  = 63;
   localparam int DIV_W    = 64;
   localparam int CNT_W    = 7;
   localparam int CSR_IDX_W = 3;

   localparam int DEF_X_BINS = 64;
   localparam int DEF_Y_BINS = 64;
   localparam int DEF_Z_BINS = 64;

   localparam logic signed [ORIGIN_W-1:0] RST_X_ORIGIN = -21'sd75750;
   localparam logic signed [ORIGIN_W-1:0] RST_Y_ORIGIN = -21'sd75750;
   localparam logic signed [ORIGIN_W-1:0] RST_Z_ORIGIN = -21'sd50000;
   localparam logic [WIDTH_W-1:0] RST_X_WIDTH = 16'd1500;
   localparam logic [WIDTH_W-1:0] RST_Y_WIDTH = 16'd1500;
   localparam logic [WIDTH_W-1:0] RST_Z_WIDTH = 16'd500;

   localparam logic [CNT_W-1:0] AXIS_STEPS = 7'd22;
   localparam logic [CNT_W-1:0] DOSE_STEPS = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN = 3'd0,
      CSR_Y_ORIGIN = 3'd1,
      CSR_Z_ORIGIN = 3'd2,
      CSR_X_WIDTH  = 3'd3,
      CSR_Y_WIDTH  = 3'd4,
      CSR_Z_WIDTH  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/core/voxel_dose_accumulator.sv
// voxel dose accumulator: 3d histogram of energy deposits
// req channel: tuser carries the request kind (deposit or read), tdata the hit
// fields and the voxel index of a read. rsp channel: one transfer per request,
// tuser holds the accepted flag, tdata the three 64-bit sums of a read
// (zero for a deposit). csr channel, always ready: the user is to write the grid
// origins and voxel widths only while idle, which the block does not enforce.
// a deposit divides the offset on each axis by the voxel width in a shared
// restoring divider (22 steps per axis), builds density * volume in three
// multiply steps, divides energy<<32 by it (64 steps) and then does a read,
// saturating add and write on the voxel store. one request is in flight at
// a time and req_tready is high only while the sequencer idles.
// after reset a clearing pass writes zero to each of the X_BINS*Y_BINS*Z_BINS
// voxels (262144 by default), one per cycle, with req_tready low.
// a finished response waits in an output register while rsp_tready is low;
// the next request may be accepted meanwhile but its response waits behind.
module voxel_dose_accumulator #(
   parameter int X_BINS = vda_pkg::DEF_X_BINS,
   parameter int Y_BINS = vda_pkg::DEF_Y_BINS,
   parameter int Z_BINS = vda_pkg::DEF_Z_BINS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, energy, density, weight, read_x, read_y, read_z
   input  logic [159:0] req_tdata,
   // req_type
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // dose_total, energy_sq_total, weight_total
   output logic [191:0] rsp_tdata,
   // accepted
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [vda_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vda_pkg::ORIGIN_W-1:0]  csr_data
);

   localparam int DEPTH = X_BINS * Y_BINS * Z_BINS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (X_BINS > 1) ? $clog2(X_BINS) : 1;
   localparam int YW    = (Y_BINS > 1) ? $clog2(Y_BINS) : 1;
   localparam int ZW    = (Z_BINS > 1) ? $clog2(Z_BINS) : 1;
   localparam int SW    = vda_pkg::SUM_W;
   localparam int DW    = 3 * SW;

   typedef enum logic [11:0] {
      ST_CLEAR      = 12'b000000000001,
      ST_IDLE       = 12'b000000000010,
      ST_AX_START   = 12'b000000000100,
      ST_AX_WAIT    = 12'b000000001000,
      ST_MUL1       = 12'b000000010000,
      ST_MUL2       = 12'b000000100000,
      ST_MUL3       = 12'b000001000000,
      ST_DOSE_START = 12'b000010000000,
      ST_DOSE_WAIT  = 12'b000100000000,
      ST_READ       = 12'b001000000000,
      ST_FETCH      = 12'b010000000000,
      ST_DONE       = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [vda_pkg::ORIGIN_W-1:0] xorg_ff, xorg_in, yorg_ff, yorg_in, zorg_ff, zorg_in;
   logic [vda_pkg::WIDTH_W-1:0] xwid_ff, xwid_in, ywid_ff, ywid_in, zwid_ff, zwid_in;

   logic                           is_read_ff, is_read_in;
   logic [vda_pkg::POS_W-1:0]      px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [vda_pkg::ENERGY_W-1:0]   en_ff, en_in;
   logic [vda_pkg::DENS_W-1:0]     dens_ff, dens_in;
   logic [vda_pkg::WGT_W-1:0]      wgt_ff, wgt_in;
   logic [XW-1:0]                  xi_ff, xi_in;
   logic [YW-1:0]                  yi_ff, yi_in;
   logic [ZW-1:0]                  zi_ff, zi_in;
   logic [1:0]                     axis_ff, axis_in;
   logic [31:0]                    p1_ff, p1_in;
   logic [47:0]                    p2_ff, p2_in;
   logic [vda_pkg::DENOM_W-1:0]    denom_ff, denom_in;
   logic [SW-1:0]                  esq_ff, esq_in;
   logic [SW-1:0]                  dose_ff, dose_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic                           pend_acc_ff, pend_acc_in;
   logic [DW-1:0]                  pend_data_ff, pend_data_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_acc_ff, rsp_acc_in;
   logic [DW-1:0]                  rsp_data_ff, rsp_data_in;

   logic                           req_fire;
   logic [vda_pkg::POS_W-1:0]      ax_pos;
   logic [vda_pkg::ORIGIN_W-1:0]   ax_org;
   logic [vda_pkg::WIDTH_W-1:0]    ax_wid;
   logic [vda_pkg::OFF_W-1:0]      ax_bins;
   logic [vda_pkg::OFF_W-1:0]      ax_off;
   logic [vda_pkg::OFF_W-1:0]      ax_q;

   vda_pkg::div_ctl_type           div_ctl;
   vda_pkg::div_stat_type          div_stat;
   logic [vda_pkg::DIV_W-1:0]      div_dividend, div_divisor, div_quotient;

   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr, addr;
   logic [DW-1:0]                  mem_wdata, mem_rdata;
   logic [SW:0]                    sum_dose, sum_esq, sum_wgt;
   logic [SW-1:0]                  new_dose, new_esq, new_wgt;
   logic                           read_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign addr = AW'(xi_ff) * AW'(Y_BINS * Z_BINS) + AW'(yi_ff) * AW'(Z_BINS) + AW'(zi_ff);

   assign read_ok = ({3'b000, req_tdata[147:142]} < 9'(X_BINS)) &&
                    ({3'b000, req_tdata[153:148]} < 9'(Y_BINS)) &&
                    ({3'b000, req_tdata[159:154]} < 9'(Z_BINS));

   always_comb begin
      ax_pos  = px_ff;
      ax_org  = xorg_ff;
      ax_wid  = xwid_ff;
      ax_bins = vda_pkg::OFF_W'(X_BINS);
      case (axis_ff)
         2'd1: begin
            ax_pos  = py_ff;
            ax_org  = yorg_ff;
            ax_wid  = ywid_ff;
            ax_bins = vda_pkg::OFF_W'(Y_BINS);
         end
         2'd2: begin
            ax_pos  = pz_ff;
            ax_org  = zorg_ff;
            ax_wid  = zwid_ff;
            ax_bins = vda_pkg::OFF_W'(Z_BINS);
         end
         default: begin
         end
      endcase
      ax_off = {ax_pos[vda_pkg::POS_W-1], ax_pos} - {ax_org[vda_pkg::ORIGIN_W-1], ax_org};
      ax_q   = div_quotient[vda_pkg::OFF_W-1:0];
   end

   always_comb begin
      sum_dose = {1'b0, mem_rdata[SW-1:0]} + {1'b0, dose_ff};
      sum_esq  = {1'b0, mem_rdata[2*SW-1:SW]} + {1'b0, esq_ff};
      sum_wgt  = {1'b0, mem_rdata[3*SW-1:2*SW]} + {{(SW-vda_pkg::WGT_W+1){1'b0}}, wgt_ff};
      new_dose = sum_dose[SW] ? '1 : sum_dose[SW-1:0];
      new_esq  = sum_esq[SW]  ? '1 : sum_esq[SW-1:0];
      new_wgt  = sum_wgt[SW]  ? '1 : sum_wgt[SW-1:0];
   end

   always_comb begin
      xorg_in = xorg_ff;
      yorg_in = yorg_ff;
      zorg_in = zorg_ff;
      xwid_in = xwid_ff;
      ywid_in = ywid_ff;
      zwid_in = zwid_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vda_pkg::CSR_X_ORIGIN: xorg_in = csr_data;
            vda_pkg::CSR_Y_ORIGIN: yorg_in = csr_data;
            vda_pkg::CSR_Z_ORIGIN: zorg_in = csr_data;
            vda_pkg::CSR_X_WIDTH:  xwid_in = csr_data[vda_pkg::WIDTH_W-1:0];
            vda_pkg::CSR_Y_WIDTH:  ywid_in = csr_data[vda_pkg::WIDTH_W-1:0];
            vda_pkg::CSR_Z_WIDTH:  zwid_in = csr_data[vda_pkg::WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      is_read_in   = is_read_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      en_in        = en_ff;
      dens_in      = dens_ff;
      wgt_in       = wgt_ff;
      xi_in        = xi_ff;
      yi_in        = yi_ff;
      zi_in        = zi_ff;
      axis_in      = axis_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      denom_in     = denom_ff;
      esq_in       = esq_ff;
      dose_in      = dose_ff;
      clr_in       = clr_ff;
      pend_acc_in  = pend_acc_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_data_in  = rsp_data_ff;
      div_ctl      = '0;
      div_dividend = '0;
      div_divisor  = '0;
      mem_we       = 1'b0;
      mem_waddr    = addr;
      mem_wdata    = {new_wgt, new_esq, new_dose};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               is_read_in   = req_tuser[0];
               px_in        = req_tdata[20:0];
               py_in        = req_tdata[41:21];
               pz_in        = req_tdata[62:42];
               en_in        = req_tdata[94:63];
               dens_in      = req_tdata[109:95];
               wgt_in       = req_tdata[141:110];
               xi_in        = XW'(req_tdata[147:142]);
               yi_in        = YW'(req_tdata[153:148]);
               zi_in        = ZW'(req_tdata[159:154]);
               axis_in      = 2'd0;
               pend_acc_in  = 1'b0;
               pend_data_in = '0;
               if (req_tuser[0]) begin
                  state_in = read_ok ? ST_READ : ST_DONE;
               end else if (req_tdata[94:63] == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_AX_START;
               end
            end
         end
         ST_AX_START: begin
            if (ax_wid == '0 || ax_off[vda_pkg::OFF_W-1]) begin
               state_in = ST_DONE;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.steps = vda_pkg::AXIS_STEPS;
               div_dividend  = {ax_off, {(vda_pkg::DIV_W-vda_pkg::OFF_W){1'b0}}};
               div_divisor   = {{(vda_pkg::DIV_W-vda_pkg::WIDTH_W){1'b0}}, ax_wid};
               state_in      = ST_AX_WAIT;
            end
         end
         ST_AX_WAIT: begin
            if (div_stat.done) begin
               if (ax_q >= ax_bins) begin
                  state_in = ST_DONE;
               end else begin
                  case (axis_ff)
                     2'd0:    xi_in = ax_q[XW-1:0];
                     2'd1:    yi_in = ax_q[YW-1:0];
                     default: zi_in = ax_q[ZW-1:0];
                  endcase
                  axis_in  = axis_ff + 1'b1;
                  state_in = (axis_ff == 2'd2) ? ST_MUL1 : ST_AX_START;
               end
            end
         end
         ST_MUL1: begin
            p1_in    = xwid_ff * ywid_ff;
            esq_in   = en_ff * en_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p2_in    = p1_ff * zwid_ff;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            denom_in = p2_ff * dens_ff;
            state_in = ST_DOSE_START;
         end
         ST_DOSE_START: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = vda_pkg::DOSE_STEPS;
            div_dividend  = {en_ff, {(vda_pkg::DIV_W-vda_pkg::ENERGY_W){1'b0}}};
            div_divisor   = {1'b0, denom_ff};
            state_in      = ST_DOSE_WAIT;
         end
         ST_DOSE_WAIT: begin
            if (div_stat.done) begin
               dose_in  = div_quotient;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            pend_acc_in = 1'b1;
            if (is_read_ff) begin
               pend_data_in = mem_rdata;
            end else begin
               mem_we = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = pend_acc_ff;
               rsp_data_in  = pend_data_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      is_read_ff   <= is_read_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      en_ff        <= en_in;
      dens_ff      <= dens_in;
      wgt_ff       <= wgt_in;
      xi_ff        <= xi_in;
      yi_ff        <= yi_in;
      zi_ff        <= zi_in;
      axis_ff      <= axis_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      denom_ff     <= denom_in;
      esq_ff       <= esq_in;
      dose_ff      <= dose_in;
      pend_acc_ff  <= pend_acc_in;
      pend_data_ff <= pend_data_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         xorg_ff      <= vda_pkg::RST_X_ORIGIN;
         yorg_ff      <= vda_pkg::RST_Y_ORIGIN;
         zorg_ff      <= vda_pkg::RST_Z_ORIGIN;
         xwid_ff      <= vda_pkg::RST_X_WIDTH;
         ywid_ff      <= vda_pkg::RST_Y_WIDTH;
         zwid_ff      <= vda_pkg::RST_Z_WIDTH;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         xorg_ff      <= xorg_in;
         yorg_ff      <= yorg_in;
         zorg_ff      <= zorg_in;
         xwid_ff      <= xwid_in;
         ywid_ff      <= ywid_in;
         zwid_ff      <= zwid_in;
      end
   end

   vda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   vda_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (addr),
      .rdata (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_acc_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("store written while idle");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_AX_WAIT || state_ff == ST_DOSE_WAIT))
      else $error("divider busy outside a divide state");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while another is in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

endmodule

>>> rtl/core/vda_div.sv
module vda_div (
   input  logic                        clock,
   input  logic                        reset,
   input  vda_pkg::div_ctl_type        ctl,
   input  logic [vda_pkg::DIV_W-1:0]   dividend,
   input  logic [vda_pkg::DIV_W-1:0]   divisor,
   output vda_pkg::div_stat_type       stat,
   output logic [vda_pkg::DIV_W-1:0]   quotient
);

   logic [vda_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [vda_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [vda_pkg::DIV_W-1:0] dvs_ff, dvs_in;
   logic [vda_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [vda_pkg::DIV_W:0]   rem_sh;
   logic [vda_pkg::DIV_W+1:0] diff;
   logic                      ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[vda_pkg::DIV_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      ge      = !diff[vda_pkg::DIV_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = ctl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[vda_pkg::DIV_W-1:0] : rem_sh[vda_pkg::DIV_W-1:0];
         quo_in = {quo_ff[vda_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == vda_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> rtl/core/vda_store.sv
module vda_store #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18,
   parameter int DW    = 192
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
